### rtl/ebsf_pkg.sv
package ebsf_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Configuration port geometry and register select codes (paddr[2])
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_OWN_ADDRESS = 1'b0;
    localparam logic REG_BUFFER_LIMIT = 1'b1;

    localparam logic [6:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_HELLO  = 2'd0,
        CMD_RECV   = 2'd1,
        CMD_CREATE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FORWARD   = 3'd0,
        ST_DELIVERED = 3'd1,
        ST_STORED    = 3'd2,
        ST_DUP       = 3'd3,
        ST_FULL      = 3'd4,
        ST_CREATED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } state_t;

    // One stored bundle
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] size;
    } entry_t;

    // Write request into the bundle store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } store_wr_t;

    // Read request into the bundle store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } store_rd_t;

    // One result
    typedef struct packed {
        status_t          status;
        logic [31:0]      id;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [15:0]      size;
        logic [31:0]      hop;
        logic [CNT_W-1:0] occ;
        logic             last;
    } result_t;

endpackage

### rtl/ebsf_store.sv
module ebsf_store
    import ebsf_pkg::*;
(
    input  logic      clk,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output entry_t    rdata
);

    entry_t mem [STORE_DEPTH];
    entry_t rdata_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read one entry per cycle, hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/epidemic_bundle_store_forward_unit.sv
// Epidemic store-carry-forward bundle buffer. Each request is a command: a
// neighbor hello forwards every held bundle whose source differs from the
// neighbor (in insertion order, last marked on the final one, no result if
// none qualifies), a received bundle is delivered, stored or dropped as a
// duplicate or for lack of room, and a create stores a bundle with the next
// id from the local counter if there is room. The unit works on one request
// at a time and holds in_stall high while busy. A hello or a received
// bundle that is not for this node walks the bundle store (separate read
// and write ports) one entry per cycle while the output is not stalled; a
// create or a delivery skips the walk. A result ready while the output is
// stalled holds the request for every stalled cycle. There is no clearing
// pass after reset: stored entries above the fill count are never read.
module epidemic_bundle_store_forward_unit
    import ebsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // APB-style configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // Request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [31:0]        bundle_id,
    input  logic [31:0]        source_addr,
    input  logic [31:0]        dest_addr,
    input  logic [15:0]        payload_size,

    // Result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [31:0]        out_bundle_id,
    output logic [31:0]        out_source,
    output logic [31:0]        out_dest,
    output logic [15:0]        out_size,
    output logic [31:0]        next_hop,
    output logic [CNT_W-1:0]   occupancy,
    output logic               last
);

    // Configuration registers
    logic [31:0]      own_addr_reg;
    logic [6:0]       limit_reg;

    // Sequencer state
    state_t           state_reg, state_next;
    cmd_t             op_reg;
    logic [31:0]      id_reg;
    logic [31:0]      src_reg;
    logic [31:0]      dst_reg;
    logic [15:0]      size_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             dvld_reg;
    logic             dup_reg;
    logic             pvld_reg;
    entry_t           pend_reg;

    // Store bookkeeping
    logic [CNT_W-1:0] held_count_reg;
    logic [31:0]      id_counter_reg;

    // Output register
    logic             out_valid_reg;
    result_t          out_reg;

    // Datapath signals
    store_wr_t        st_wr;
    store_rd_t        st_rd;
    entry_t           rd_data;
    logic             cfg_write;
    logic             accept;
    logic             is_hello;
    logic             match;
    logic             out_free;
    logic             need_out;
    logic             consume_ok;
    logic             advance;
    logic             scan_more;
    logic [CNT_W-1:0] eff_limit;
    logic             full;
    logic             do_store;
    logic             done_emit;
    logic             scan_emit;
    logic [31:0]      next_id;
    result_t          res_done;
    result_t          res_fwd;

    ebsf_store u_store
    (
        .clk   (clk),
        .wr    (st_wr),
        .rd    (st_rd),
        .rdata (rd_data)
    );

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= '0;
            limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_OWN_ADDRESS:  own_addr_reg <= pwdata[31:0];
                REG_BUFFER_LIMIT: limit_reg    <= pwdata[6:0];
                default:          own_addr_reg <= own_addr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OWN_ADDRESS:  prdata = own_addr_reg;
            REG_BUFFER_LIMIT: prdata = {{(PDATA_W-7){1'b0}}, limit_reg};
            default:          prdata = '0;
        endcase
    end

    // Handshakes
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Scan compare: source mismatch for hello, id hit for received bundle
    assign is_hello   = (op_reg == CMD_HELLO);
    assign match      = is_hello ? (rd_data.src != src_reg) : (rd_data.id == id_reg);
    assign need_out   = dvld_reg && match && is_hello && pvld_reg;
    assign consume_ok = !need_out || out_free;
    assign advance    = !dvld_reg || consume_ok;
    assign scan_more  = (scan_reg < held_count_reg);
    assign scan_emit  = (state_reg == S_SCAN) && need_out && out_free;

    // Limit saturates at store depth
    assign eff_limit = (limit_reg > 7'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                     : CNT_W'(limit_reg);
    assign full      = (held_count_reg >= eff_limit);
    assign next_id   = id_counter_reg + 32'd1;

    // Forward result from the pending entry
    always_comb
    begin
        res_fwd.status = ST_FORWARD;
        res_fwd.id     = pend_reg.id;
        res_fwd.src    = pend_reg.src;
        res_fwd.dst    = pend_reg.dst;
        res_fwd.size   = pend_reg.size;
        res_fwd.hop    = src_reg;
        res_fwd.occ    = held_count_reg;
        res_fwd.last   = 1'b0;
    end

    // Final result of the request
    always_comb
    begin
        res_done.status = ST_FULL;
        res_done.id     = id_reg;
        res_done.src    = src_reg;
        res_done.dst    = dst_reg;
        res_done.size   = size_reg;
        res_done.hop    = 32'd0;
        res_done.occ    = held_count_reg;
        res_done.last   = 1'b1;
        do_store        = 1'b0;
        case (op_reg)
            CMD_HELLO:
            begin
                res_done      = res_fwd;
                res_done.last = 1'b1;
            end
            CMD_RECV:
            begin
                if (dst_reg == own_addr_reg)
                begin
                    res_done.status = ST_DELIVERED;
                end
                else if (dup_reg)
                begin
                    res_done.status = ST_DUP;
                end
                else if (full)
                begin
                    res_done.status = ST_FULL;
                end
                else
                begin
                    res_done.status = ST_STORED;
                    res_done.occ    = held_count_reg + CNT_W'(1);
                    do_store        = 1'b1;
                end
            end
            CMD_CREATE:
            begin
                res_done.id  = next_id;
                res_done.src = own_addr_reg;
                if (!full)
                begin
                    res_done.status = ST_CREATED;
                    res_done.occ    = held_count_reg + CNT_W'(1);
                    do_store        = 1'b1;
                end
            end
            default:
            begin
                do_store = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_HELLO)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (command == CMD_RECV)
                    begin
                        state_next = (dest_addr == own_addr_reg) ? S_DONE : S_SCAN;
                    end
                    else if (command == CMD_CREATE)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (advance && !scan_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if ((is_hello && !pvld_reg) || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: store read, store write, final emit
    always_comb
    begin
        st_rd.en   = 1'b0;
        st_rd.addr = scan_reg[IDX_W-1:0];
        st_wr.en   = 1'b0;
        st_wr.addr = held_count_reg[IDX_W-1:0];
        st_wr.data = '{id: res_done.id, src: res_done.src, dst: res_done.dst,
                       size: res_done.size};
        done_emit  = 1'b0;
        unique case (state_reg)
            S_SCAN:
            begin
                st_rd.en = advance && scan_more;
            end
            S_DONE:
            begin
                done_emit = out_free && !(is_hello && !pvld_reg);
                st_wr.en  = out_free && do_store;
            end
            default:
            begin
                st_rd.en = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= CMD_HELLO;
            scan_reg       <= '0;
            dvld_reg       <= 1'b0;
            dup_reg        <= 1'b0;
            pvld_reg       <= 1'b0;
            held_count_reg <= '0;
            id_counter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    // Latch the request and start a fresh walk
                    if (accept)
                    begin
                        op_reg <= cmd_t'(command);
                    end
                    scan_reg <= '0;
                    dvld_reg <= 1'b0;
                    dup_reg  <= 1'b0;
                    pvld_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    // Advance the walk one entry
                    if (advance)
                    begin
                        dvld_reg <= st_rd.en;
                        if (st_rd.en)
                        begin
                            scan_reg <= scan_reg + CNT_W'(1);
                        end
                    end
                    if (dvld_reg && match && !is_hello)
                    begin
                        dup_reg <= 1'b1;
                    end
                    if (dvld_reg && match && is_hello && consume_ok)
                    begin
                        pvld_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (done_emit)
                    begin
                        pvld_reg <= 1'b0;
                    end
                    if (st_wr.en)
                    begin
                        held_count_reg <= held_count_reg + CNT_W'(1);
                        if (op_reg == CMD_CREATE)
                        begin
                            id_counter_reg <= next_id;
                        end
                    end
                end
                default:
                begin
                    dvld_reg <= 1'b0;
                end
            endcase
        end
    end

    // Request payload and pending forward entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg   <= bundle_id;
            src_reg  <= source_addr;
            dst_reg  <= dest_addr;
            size_reg <= payload_size;
        end
        if ((state_reg == S_SCAN) && dvld_reg && match && is_hello && consume_ok)
        begin
            pend_reg <= rd_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (scan_emit || done_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_emit)
        begin
            out_reg <= res_fwd;
        end
        else if (done_emit)
        begin
            out_reg <= res_done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign out_bundle_id = out_reg.id;
    assign out_source    = out_reg.src;
    assign out_dest      = out_reg.dst;
    assign out_size      = out_reg.size;
    assign next_hop      = out_reg.hop;
    assign occupancy     = out_reg.occ;
    assign last          = out_reg.last;

    // Fill count never passes store depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(STORE_DEPTH))
        else $error("held count above store depth");

    // Walk never reads past the fill count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg <= held_count_reg))
        else $error("scan index past fill count");

    // Fill count changes only while finishing a request
    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DONE) |=> $stable(held_count_reg))
        else $error("fill count changed outside completion");

    // A pending forward exists only during a hello
    a_pend_hello: assert property (@(posedge clk) disable iff (!rst_n)
        pvld_reg |-> (op_reg == CMD_HELLO))
        else $error("pending forward outside hello");

    // New results are never loaded over a stalled result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(scan_emit || done_emit))
        else $error("result register overrun");

endmodule
